// ----- rtl/qpf_pkg.sv -----
// Shared types, constants and helpers for the QRS pre-processing filter chain.
// No dependencies; every other file but qpf_checker imports this package.
package qpf_pkg;

    // Word widths
    localparam int SAMPLE_W = 12;
    localparam int DATA_W   = 32;
    localparam int FIR_W    = 14;   // x - 2*x6 + x12 stays within +/-8190

    // Raw sample shift line: holds the previous twelve samples
    localparam int RAW_TAPS    = 12;
    localparam int RAW_MID_TAP = 5;   // sample six items back

    // Low-pass history RAM: ring of the last 32 low-pass outputs
    localparam int LP_RING_DEPTH = 32;
    localparam int LP_RING_AW    = $clog2(LP_RING_DEPTH);
    localparam int LP_CNT_W      = $clog2(LP_RING_DEPTH + 1);
    localparam int LP_MID_OFS    = 16;
    localparam logic [LP_RING_AW-1:0] LP_MID_ADDR_OFS = LP_RING_AW'(LP_MID_OFS);

    // High-pass taps: current output and four before it
    localparam int HP_TAPS = 5;

    // Truncating divide shifts
    localparam logic [4:0] LP_DIV_SH    = 5'd5;   // divide by 32
    localparam logic [4:0] SLOPE_DIV_SH = 5'd3;   // divide by 8

    // Moving window default length
    localparam int WINDOW_LEN_DEF = 30;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [FIR_W-1:0]    t_fir;
    typedef logic signed [DATA_W-1:0]   t_data;

    // One word traveling down the chain; window holds the sum, later the mean
    typedef struct packed {
        t_data lowpass;
        t_data highpass;
        t_data slope;
        t_data window;
    } t_chain_word;

    // Signed divide by 2**sh, truncating toward zero
    function automatic t_data f_sdiv_pow2(input t_data v, input logic [4:0] sh);
        logic [DATA_W-1:0] mask;
        t_data             bias;
        mask = ~({DATA_W{1'b1}} << sh);
        bias = v[DATA_W-1] ? t_data'(mask) : '0;
        return (v + bias) >>> sh;
    endfunction

endpackage

// ----- rtl/qpf_front.sv -----
// Front end of the chain: low-pass, high-pass and five-point derivative.
// Keeps low-pass history in a two-read-port ring RAM; depends on qpf_pkg.
module qpf_front
    import qpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_vld,
    input  t_sample     i_sample,
    output logic        o_vld,
    output t_chain_word o_word
);

    // Sample shift line and low-pass recursion state
    t_sample r_raw [RAW_TAPS];
    t_data   r_lp1;
    t_data   r_lp2;

    // Low-pass history RAM and its pointer / fill count
    t_data                 r_lp_mem [LP_RING_DEPTH];
    logic [LP_RING_AW-1:0] r_lp_ptr;
    logic [LP_CNT_W-1:0]   r_lp_cnt;
    t_data                 r_rd_old;
    t_data                 r_rd_mid;

    // Stage 1
    logic  r_v1;
    logic  r_mid_ok;
    logic  r_old_ok;
    t_data r_s1_lp;

    // High-pass state
    t_data r_lp17;
    t_data r_hp [HP_TAPS];

    // Stage 2 and output stage
    logic        r_v2;
    t_data       r_s2_lp;
    logic        r_v3;
    t_chain_word r_s3_word;

    logic                  acc;
    logic [LP_RING_AW-1:0] mid_addr;
    t_fir                  fir;
    t_data                 n_lp;
    t_data                 lp16;
    t_data                 lp32;
    t_data                 n_hp;
    t_data                 d;
    t_data                 n_slope;

    assign acc      = i_vld & i_adv;
    assign mid_addr = r_lp_ptr + LP_MID_ADDR_OFS;

    // Low-pass: FIR part over raw taps, then the double-pole recursion
    always_comb begin
        fir  = t_fir'(i_sample) - (t_fir'(r_raw[RAW_MID_TAP]) <<< 1)
             + t_fir'(r_raw[RAW_TAPS-1]);
        n_lp = (r_lp1 <<< 1) - r_lp2 + f_sdiv_pow2(t_data'(fir), LP_DIV_SH);
    end

    // High-pass over low-pass history; unfilled entries read as zero
    always_comb begin
        lp16 = r_mid_ok ? r_rd_mid : '0;
        lp32 = r_old_ok ? r_rd_old : '0;
        n_hp = r_hp[0] - f_sdiv_pow2(r_s1_lp, LP_DIV_SH) + lp16 - r_lp17
             + f_sdiv_pow2(lp32, LP_DIV_SH);
    end

    // Derivative over the high-pass taps (newest in entry 0)
    always_comb begin
        d       = (r_hp[0] <<< 1) + r_hp[1] - r_hp[3] - (r_hp[4] <<< 1);
        n_slope = f_sdiv_pow2(d, SLOPE_DIV_SH);
    end

    // Shift in the raw sample and advance the low-pass recursion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RAW_TAPS; i++) begin
                r_raw[i] <= '0;
            end
            r_lp1    <= '0;
            r_lp2    <= '0;
            r_lp_ptr <= '0;
            r_lp_cnt <= '0;
        end else if (acc) begin
            r_raw[0] <= i_sample;
            for (int i = 1; i < RAW_TAPS; i++) begin
                r_raw[i] <= r_raw[i-1];
            end
            r_lp1    <= n_lp;
            r_lp2    <= r_lp1;
            r_lp_ptr <= r_lp_ptr + 1'b1;
            if (r_lp_cnt != LP_CNT_W'(LP_RING_DEPTH)) begin
                r_lp_cnt <= r_lp_cnt + 1'b1;
            end
        end
    end

    // Ring RAM: write the new output, read 32 back (same slot) and 16 back
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lp_mem[r_lp_ptr] <= n_lp;
            r_rd_old           <= r_lp_mem[r_lp_ptr];
            r_rd_mid           <= r_lp_mem[mid_addr];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_lp  <= n_lp;
            r_mid_ok <= (r_lp_cnt >= LP_CNT_W'(LP_MID_OFS));
            r_old_ok <= (r_lp_cnt == LP_CNT_W'(LP_RING_DEPTH));
        end
    end

    // High-pass history: advance with each word leaving stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp17 <= '0;
            for (int i = 0; i < HP_TAPS; i++) begin
                r_hp[i] <= '0;
            end
        end else if (i_adv && r_v1) begin
            r_lp17  <= lp16;
            r_hp[0] <= n_hp;
            for (int i = 1; i < HP_TAPS; i++) begin
                r_hp[i] <= r_hp[i-1];
            end
        end
    end

    // Stage 2 and output payload
    always_ff @(posedge i_clk) begin
        if (i_adv && r_v1) begin
            r_s2_lp <= r_s1_lp;
        end
        if (i_adv && r_v2) begin
            r_s3_word.lowpass  <= r_s2_lp;
            r_s3_word.highpass <= r_hp[0];
            r_s3_word.slope    <= n_slope;
            r_s3_word.window   <= '0;
        end
    end

    assign o_vld  = r_v3;
    assign o_word = r_s3_word;

endmodule

// ----- rtl/qpf_window.sv -----
// Squaring and moving-window sum over a ring RAM of squared slopes.
// Depends on qpf_pkg; fed by qpf_front, feeds qpf_mean_div.
module qpf_window
    import qpf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_vld,
    input  t_chain_word i_word,
    output logic        o_vld,
    output t_chain_word o_word
);

    localparam int WIN_AW = $clog2(WINDOW_LEN);
    localparam int WIN_CW = $clog2(WINDOW_LEN + 1);
    localparam logic [WIN_AW-1:0] LAST_ADDR = WIN_AW'(WINDOW_LEN - 1);

    t_data             r_sq_mem [WINDOW_LEN];
    logic [WIN_AW-1:0] r_rptr;
    logic [WIN_AW-1:0] r_wptr;
    logic [WIN_CW-1:0] r_cnt;
    t_data             r_rd_old;
    logic              r_old_ok;
    logic              r_v4;
    t_chain_word       r_s4_word;
    t_data             r_s4_sq;
    t_data             r_sum;
    logic              r_v5;
    t_chain_word       r_s5_word;

    logic  acc;
    logic  wr;
    t_data n_sq;
    t_data old;
    t_data n_sum;

    assign acc = i_adv & i_vld;
    assign wr  = i_adv & r_v4;

    // Square, keeping the low word of the product
    assign n_sq = i_word.slope * i_word.slope;

    // Drop the oldest square and add the newest
    always_comb begin
        old   = r_old_ok ? r_rd_old : '0;
        n_sum = r_sum - old + r_s4_sq;
    end

    // Ring RAM: read the slot a word will replace, write one stage later
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_old <= r_sq_mem[r_rptr];
        end
        if (wr) begin
            r_sq_mem[r_wptr] <= r_s4_sq;
        end
    end

    // Pointers, fill count and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr <= '0;
            r_wptr <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
        end else begin
            if (acc) begin
                r_rptr <= (r_rptr == LAST_ADDR) ? '0 : r_rptr + 1'b1;
                if (r_cnt != WIN_CW'(WINDOW_LEN)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (wr) begin
                r_wptr <= (r_wptr == LAST_ADDR) ? '0 : r_wptr + 1'b1;
                r_sum  <= n_sum;
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_adv) begin
            r_v4 <= i_vld;
            r_v5 <= r_v4;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s4_word <= i_word;
            r_s4_sq   <= n_sq;
            r_old_ok  <= (r_cnt == WIN_CW'(WINDOW_LEN));
        end
        if (wr) begin
            r_s5_word.lowpass  <= r_s4_word.lowpass;
            r_s5_word.highpass <= r_s4_word.highpass;
            r_s5_word.slope    <= r_s4_word.slope;
            r_s5_word.window   <= n_sum;
        end
    end

    assign o_vld  = r_v5;
    assign o_word = r_s5_word;

endmodule

// ----- rtl/qpf_mean_div.sv -----
// Signed divide of the window sum by the window length, truncating toward zero.
// Reciprocal multiply with a one-step correction; depends on qpf_pkg.
module qpf_mean_div
    import qpf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_vld,
    input  t_chain_word i_word,
    output logic        o_vld,
    output t_chain_word o_word
);

    // floor(2**32 / WINDOW_LEN): quotient estimate is low by at most one
    localparam logic [2*DATA_W-1:0] RECIP_WIDE = 64'h1_0000_0000 / WINDOW_LEN;
    localparam logic [DATA_W-1:0]   RECIP      = RECIP_WIDE[DATA_W-1:0];
    localparam logic [DATA_W-1:0]   WIN_C      = DATA_W'(WINDOW_LEN);

    logic              r_v6;
    logic              r_v7;
    logic              r_v8;
    t_chain_word       r_s6_word;
    t_chain_word       r_s7_word;
    t_chain_word       r_s8_word;
    logic [DATA_W-1:0] r_s6_abs;
    logic [DATA_W-1:0] r_s7_abs;
    logic [DATA_W-1:0] r_s8_abs;
    logic              r_s6_neg;
    logic              r_s7_neg;
    logic              r_s8_neg;
    logic [DATA_W-1:0] r_s7_q0;
    logic [DATA_W-1:0] r_s8_q0;
    logic [DATA_W-1:0] r_s8_qw;

    logic                n_neg;
    logic [DATA_W-1:0]   n_abs;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   n_qw;
    logic [DATA_W-1:0]   rem;
    logic [DATA_W-1:0]   quo;
    t_data               mean;

    // Magnitude and sign of the sum
    always_comb begin
        n_neg = i_word.window[DATA_W-1];
        n_abs = n_neg ? (~i_word.window + 1'b1) : i_word.window;
    end

    // Quotient estimate, then back-multiply
    assign prod = {{DATA_W{1'b0}}, r_s6_abs} * {{DATA_W{1'b0}}, RECIP};
    assign n_qw = r_s7_q0 * WIN_C;

    // Correct the estimate and restore the sign
    always_comb begin
        rem  = r_s8_abs - r_s8_qw;
        quo  = r_s8_q0 + DATA_W'(rem >= WIN_C);
        mean = r_s8_neg ? t_data'(~quo + 1'b1) : t_data'(quo);
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_adv) begin
            r_v6 <= i_vld;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_adv && i_vld) begin
            r_s6_word <= i_word;
            r_s6_abs  <= n_abs;
            r_s6_neg  <= n_neg;
        end
        if (i_adv && r_v6) begin
            r_s7_word <= r_s6_word;
            r_s7_abs  <= r_s6_abs;
            r_s7_neg  <= r_s6_neg;
            r_s7_q0   <= prod[2*DATA_W-1:DATA_W];
        end
        if (i_adv && r_v7) begin
            r_s8_word <= r_s7_word;
            r_s8_abs  <= r_s7_abs;
            r_s8_neg  <= r_s7_neg;
            r_s8_q0   <= r_s7_q0;
            r_s8_qw   <= n_qw;
        end
    end

    always_comb begin
        o_word        = r_s8_word;
        o_word.window = mean;
    end

    assign o_vld = r_v8;

endmodule

// ----- rtl/qpf_out_buf.sv -----
// Output holding register with a skid entry behind it.
// Depends on qpf_pkg; o_full freezes the chain and stalls the input side.
module qpf_out_buf
    import qpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_chain_word i_word,
    input  logic        i_stall,
    output logic        o_valid,
    output t_chain_word o_word,
    output logic        o_full
);

    logic        r_out_vld;
    logic        r_skid_vld;
    t_chain_word r_out_word;
    t_chain_word r_skid_word;

    logic pop;

    assign pop = r_out_vld & ~i_stall;

    // Control: a push arrives only while the skid entry is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || pop) begin
            r_out_vld  <= r_skid_vld | i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Data: refill the head from the skid entry first, else from the chain
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || pop) begin
            r_out_word <= r_skid_vld ? r_skid_word : i_word;
        end else if (i_push) begin
            r_skid_word <= i_word;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out_word;
    assign o_full  = r_skid_vld;

endmodule

// ----- rtl/qrs_preprocess_filter_chain_top.sv -----
// QRS pre-processing filter chain: one ECG sample in, one result word out.
// Uses qpf_pkg, qpf_front, qpf_window, qpf_mean_div and qpf_out_buf.
//
// Input channel: i_valid / o_stall with the signed 12-bit i_sample. A word is
// taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with the low-pass, high-pass, slope and
// window-mean fields of the same sample, in sample order.
//
// Throughput: one sample per clock cycle while o_stall is low. The low-pass,
// high-pass and window-sum recursions each close within their own stage; the
// low-pass RAM serves its 16-back and 32-back taps on two read ports in the same cycle.
// A sample passes the front, window and divider stages, then the output register.
//
// Reset (i_rst_n low at a clock edge) clears every filter history, the window
// sum and every stage valid at once; RAM contents are ignored until rewritten
// through fill counts, so no clearing pass runs and a sample can be taken in
// the first cycle after reset.
// When the receiver stalls, the result waits in the output register and one
// more result lands in a skid entry; only then does o_stall rise and every
// stage hold its word until the output drains.
module qrs_preprocess_filter_chain_top
    import qpf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_sample i_sample,
    output logic    o_valid,
    input  logic    i_stall,
    output t_data   o_lowpass_out,
    output t_data   o_highpass_out,
    output t_data   o_slope_out,
    output t_data   o_window_mean_out
);

    logic        adv;
    logic        full;
    logic        front_vld;
    t_chain_word front_word;
    logic        win_vld;
    t_chain_word win_word;
    logic        div_vld;
    t_chain_word div_word;
    t_chain_word out_word;

    // Advance the whole chain while the skid entry is free
    assign adv     = ~full;
    assign o_stall = full;

    qpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_vld    (i_valid),
        .i_sample (i_sample),
        .o_vld    (front_vld),
        .o_word   (front_word)
    );

    qpf_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (front_vld),
        .i_word  (front_word),
        .o_vld   (win_vld),
        .o_word  (win_word)
    );

    qpf_mean_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (win_vld),
        .i_word  (win_word),
        .o_vld   (div_vld),
        .o_word  (div_word)
    );

    qpf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_vld & adv),
        .i_word  (div_word),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_word  (out_word),
        .o_full  (full)
    );

    assign o_lowpass_out     = out_word.lowpass;
    assign o_highpass_out    = out_word.highpass;
    assign o_slope_out       = out_word.slope;
    assign o_window_mean_out = out_word.window;

endmodule

// ----- rtl/qpf_checker.sv -----
// Port-level checks for the QRS pre-processing filter chain top level.
// Bound to qrs_preprocess_filter_chain_top at the end of this file.
module qpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_lowpass_out,
    input logic [31:0] o_highpass_out,
    input logic [31:0] o_slope_out,
    input logic [31:0] o_window_mean_out
);

    // Reset empties the output side and releases the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not cleared by reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lowpass_out)
            && $stable(o_highpass_out) && $stable(o_slope_out)
            && $stable(o_window_mean_out))
        else $error("stalled result word changed");

    // Input stall only rises after the receiver held off a waiting word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // Input stall implies a word is waiting at the output
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

endmodule

bind qrs_preprocess_filter_chain_top qpf_checker u_qpf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_lowpass_out     (o_lowpass_out),
    .o_highpass_out    (o_highpass_out),
    .o_slope_out       (o_slope_out),
    .o_window_mean_out (o_window_mean_out)
);
